### rtl/ucer_pkg.sv
package ucer_pkg;

    typedef enum logic [2:0] {
        CMD_BUS_RESET = 3'd0,
        CMD_SETUP     = 3'd1,
        CMD_EP0_DONE  = 3'd2,
        CMD_EP0_OUT   = 3'd3,
        CMD_SOF       = 3'd4,
        CMD_EP1_DONE  = 3'd5
    } cmd_t;

    localparam logic [2:0] ACT_NONE      = 3'd0;
    localparam logic [2:0] ACT_EP0_QUEUE = 3'd1;
    localparam logic [2:0] ACT_STALL     = 3'd2;
    localparam logic [2:0] ACT_SET_ADDR  = 3'd3;
    localparam logic [2:0] ACT_EP1_QUEUE = 3'd4;

    localparam logic [15:0] REQ_SET_ADDRESS = 16'h0500;
    localparam logic [15:0] REQ_SET_CONFIG  = 16'h0900;
    localparam logic [15:0] REQ_GET_DESC    = 16'h0680;
    localparam logic [15:0] REQ_GET_REPORT  = 16'h0681;

    localparam logic [7:0] DTYPE_DEVICE = 8'h01;
    localparam logic [7:0] DTYPE_CONFIG = 8'h02;
    localparam logic [7:0] DTYPE_STRING = 8'h03;

    localparam logic [2:0] SEL_STRING0 = 3'd3;
    localparam logic [2:0] SEL_ZLP     = 3'd7;

    // back end sequencer states
    typedef enum logic [1:0] {
        ST_HEAD = 2'd0,
        ST_PKT  = 2'd1
    } bstate_t;

    typedef struct packed {
        logic [2:0]  cmd;
        logic [15:0] request;
        logic [15:0] setup_value;
        logic [15:0] setup_length;
        logic        done_slot;
        logic        report_ready;
    } in_word_t;

    typedef struct packed {
        logic [2:0] action;
        logic       slot;
        logic       data_toggle;
        logic [2:0] desc_select;
        logic [7:0] byte_offset;
        logic [6:0] tx_len;
        logic [6:0] device_address;
        logic       last;
    } out_word_t;

    // classified event passed from front to back
    typedef struct packed {
        logic [2:0] cmd;
        logic       stall;
        logic       zlp;
        logic       load_desc;
        logic [2:0] sel;
        logic [7:0] len;
        logic       set_pending;
        logic [6:0] addr;
        logic       done_slot;
        logic       report_ready;
    } event_t;

    function automatic logic [7:0] desc_size(input logic [2:0] sel);
        logic [7:0] r;
        case (sel)
            3'd0:    r = 8'd18;
            3'd1:    r = 8'd34;
            3'd2:    r = 8'd23;
            3'd3:    r = 8'd4;
            3'd4:    r = 8'd18;
            3'd5:    r = 8'd18;
            default: r = 8'd0;
        endcase
        return r;
    endfunction

endpackage

### rtl/ucer_front.sv
module ucer_front
    import ucer_pkg::*;
#(
    parameter int STRING_COUNT = 3
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  in_word_t in_word,
    output logic     ev_valid,
    input  logic     ev_ready,
    output event_t   ev
);

    logic   q_valid_reg [2];
    event_t q_data_reg  [2];
    logic   wr_ptr_reg, rd_ptr_reg;
    event_t cls;
    logic [7:0] dtype, idx, size;
    logic       push, pop;

    // classify the setup request
    always_comb
    begin
        dtype = in_word.setup_value[15:8];
        idx   = in_word.setup_value[7:0];
        cls = '0;
        cls.cmd          = in_word.cmd;
        cls.addr         = in_word.setup_value[6:0];
        cls.done_slot    = in_word.done_slot;
        cls.report_ready = in_word.report_ready;
        if (in_word.request == REQ_SET_ADDRESS)
        begin
            cls.set_pending = 1'b1;
            cls.zlp         = 1'b1;
        end
        else if (in_word.request == REQ_SET_CONFIG)
            cls.zlp = 1'b1;
        else if (in_word.request == REQ_GET_DESC)
        begin
            if (dtype == DTYPE_STRING)
            begin
                if ({24'd0, idx} >= STRING_COUNT || idx >= 8'd3)
                    cls.stall = 1'b1;
                else
                    cls.sel = SEL_STRING0 + idx[2:0];
            end
            else if (dtype == DTYPE_DEVICE)
                cls.sel = 3'd0;
            else if (dtype == DTYPE_CONFIG)
                cls.sel = 3'd1;
            else
                cls.stall = 1'b1;
        end
        else if (in_word.request == REQ_GET_REPORT)
            cls.sel = 3'd2;
        else
            cls.stall = 1'b1;
        cls.load_desc = !cls.stall && !cls.zlp;
        size = desc_size(cls.sel);
        if (in_word.setup_length < {8'd0, size})
            cls.len = in_word.setup_length[7:0];
        else
            cls.len = size;
    end

    // two-entry queue
    assign in_ready = !q_valid_reg[wr_ptr_reg];
    assign push     = in_valid && in_ready;
    assign ev_valid = q_valid_reg[rd_ptr_reg];
    assign ev       = q_data_reg[rd_ptr_reg];
    assign pop      = ev_valid && ev_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q_valid_reg[0] <= 1'b0;
            q_valid_reg[1] <= 1'b0;
            wr_ptr_reg     <= 1'b0;
            rd_ptr_reg     <= 1'b0;
        end
        else
        begin
            if (push)
            begin
                q_valid_reg[wr_ptr_reg] <= 1'b1;
                wr_ptr_reg              <= !wr_ptr_reg;
            end
            if (pop)
            begin
                q_valid_reg[rd_ptr_reg] <= 1'b0;
                rd_ptr_reg              <= !rd_ptr_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            q_data_reg[wr_ptr_reg] <= cls;
    end

endmodule

### rtl/ucer_back.sv
module ucer_back
    import ucer_pkg::*;
#(
    parameter int MAX_PACKET   = 64,
    parameter int REPORT_BYTES = 1
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      ev_valid,
    output logic      ev_ready,
    input  event_t    ev,
    output logic      out_valid,
    input  logic      out_ready,
    output out_word_t out_word
);

    localparam logic [7:0] MAX_PKT_B = 8'(MAX_PACKET);
    localparam logic [6:0] REP_LEN   = 7'(REPORT_BYTES);

    bstate_t    state_reg, state_next;
    logic [1:0] pkt_cnt_reg, pkt_cnt_next;
    logic       zlp_reg, zlp_next;
    logic       ep0_pp_reg, ep0_pp_next;
    logic       ep0_tog_reg, ep0_tog_next;
    logic [1:0] ep0_busy_reg, ep0_busy_next;
    logic [7:0] rem_reg, rem_next;
    logic [2:0] desc_reg, desc_next;
    logic [7:0] off_reg, off_next;
    logic [6:0] paddr_reg, paddr_next;
    logic       ep1_pp_reg, ep1_pp_next;
    logic       ep1_tog_reg, ep1_tog_next;
    logic [1:0] ep1_busy_reg, ep1_busy_next;
    logic       out_valid_reg, out_valid_next;
    out_word_t  out_reg, out_next;

    logic       out_free, emitted_reg, emitted_next;
    logic [7:0] plen;
    logic       more;

    assign out_free  = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;
    assign out_word  = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_HEAD;
            pkt_cnt_reg   <= '0;
            zlp_reg       <= 1'b0;
            emitted_reg   <= 1'b0;
            ep0_pp_reg    <= 1'b0;
            ep0_tog_reg   <= 1'b0;
            ep0_busy_reg  <= '0;
            rem_reg       <= '0;
            desc_reg      <= '0;
            off_reg       <= '0;
            paddr_reg     <= '0;
            ep1_pp_reg    <= 1'b0;
            ep1_tog_reg   <= 1'b0;
            ep1_busy_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pkt_cnt_reg   <= pkt_cnt_next;
            zlp_reg       <= zlp_next;
            emitted_reg   <= emitted_next;
            ep0_pp_reg    <= ep0_pp_next;
            ep0_tog_reg   <= ep0_tog_next;
            ep0_busy_reg  <= ep0_busy_next;
            rem_reg       <= rem_next;
            desc_reg      <= desc_next;
            off_reg       <= off_next;
            paddr_reg     <= paddr_next;
            ep1_pp_reg    <= ep1_pp_next;
            ep1_tog_reg   <= ep1_tog_next;
            ep1_busy_reg  <= ep1_busy_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    // event execution: head step then up to two ep0 packets
    always_comb
    begin
        state_next     = state_reg;
        pkt_cnt_next   = pkt_cnt_reg;
        zlp_next       = zlp_reg;
        emitted_next   = emitted_reg;
        ep0_pp_next    = ep0_pp_reg;
        ep0_tog_next   = ep0_tog_reg;
        ep0_busy_next  = ep0_busy_reg;
        rem_next       = rem_reg;
        desc_next      = desc_reg;
        off_next       = off_reg;
        paddr_next     = paddr_reg;
        ep1_pp_next    = ep1_pp_reg;
        ep1_tog_next   = ep1_tog_reg;
        ep1_busy_next  = ep1_busy_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_next       = out_reg;
        ev_ready       = 1'b0;
        plen           = (rem_reg > MAX_PKT_B) ? MAX_PKT_B : rem_reg;
        more           = 1'b0;
        case (state_reg)
            ST_HEAD:
            begin
                if (ev_valid && out_free)
                begin
                    out_next = '0;
                    emitted_next = 1'b0;
                    zlp_next = 1'b0;
                    pkt_cnt_next = '0;
                    case (ev.cmd)
                        CMD_BUS_RESET:
                        begin
                            ev_ready = 1'b1;
                            ep0_pp_next = 1'b0;
                            ep0_tog_next = 1'b0;
                            ep0_busy_next = '0;
                            rem_next = '0;
                            desc_next = '0;
                            off_next = '0;
                            paddr_next = '0;
                            ep1_pp_next = 1'b0;
                            ep1_tog_next = 1'b0;
                            ep1_busy_next = '0;
                            out_next.last = 1'b1;
                            out_valid_next = 1'b1;
                        end
                        CMD_SETUP:
                        begin
                            ep0_busy_next = '0;
                            ep0_tog_next = 1'b1;
                            rem_next = '0;
                            zlp_next = ev.zlp;
                            if (ev.set_pending)
                                paddr_next = ev.addr;
                            if (ev.load_desc)
                            begin
                                rem_next = ev.len;
                                desc_next = ev.sel;
                                off_next = '0;
                            end
                            // a stall never has packets behind it
                            if (ev.stall)
                            begin
                                out_next.action = ACT_STALL;
                                out_next.last = 1'b1;
                                out_valid_next = 1'b1;
                                emitted_next = 1'b1;
                            end
                            state_next = ST_PKT;
                        end
                        CMD_EP0_DONE:
                        begin
                            ep0_busy_next[ev.done_slot] = 1'b0;
                            if (paddr_reg != '0)
                            begin
                                out_next.action = ACT_SET_ADDR;
                                out_next.device_address = paddr_reg;
                                // last unless a descriptor packet can follow
                                out_next.last = (rem_reg == '0) ||
                                    ep0_busy_next[ep0_pp_reg];
                                out_valid_next = 1'b1;
                                emitted_next = 1'b1;
                                paddr_next = '0;
                            end
                            state_next = ST_PKT;
                        end
                        CMD_EP0_OUT:
                            state_next = ST_PKT;
                        CMD_SOF:
                        begin
                            ev_ready = 1'b1;
                            out_next.last = 1'b1;
                            out_valid_next = 1'b1;
                            if (ev.report_ready && !ep1_busy_reg[ep1_pp_reg])
                            begin
                                out_next.action = ACT_EP1_QUEUE;
                                out_next.slot = ep1_pp_reg;
                                out_next.data_toggle = ep1_tog_reg;
                                out_next.tx_len = REP_LEN;
                                ep1_busy_next[ep1_pp_reg] = 1'b1;
                                ep1_tog_next = !ep1_tog_reg;
                                ep1_pp_next = !ep1_pp_reg;
                            end
                        end
                        CMD_EP1_DONE:
                        begin
                            ev_ready = 1'b1;
                            ep1_busy_next[ev.done_slot] = 1'b0;
                            out_next.last = 1'b1;
                            out_valid_next = 1'b1;
                        end
                        default:
                        begin
                            ev_ready = 1'b1;
                            out_next.last = 1'b1;
                            out_valid_next = 1'b1;
                        end
                    endcase
                end
            end
            ST_PKT:
            begin
                if (out_free)
                begin
                    more = (pkt_cnt_reg != 2'd2) && (rem_reg != '0 || zlp_reg)
                           && !ep0_busy_reg[ep0_pp_reg];
                    if (more)
                    begin
                        out_next = '0;
                        out_next.action = ACT_EP0_QUEUE;
                        out_next.slot = ep0_pp_reg;
                        out_next.data_toggle = ep0_tog_reg;
                        if (zlp_reg && rem_reg == '0)
                            out_next.desc_select = SEL_ZLP;
                        else
                        begin
                            out_next.desc_select = desc_reg;
                            out_next.byte_offset = off_reg;
                            out_next.tx_len = plen[6:0];
                        end
                        zlp_next = 1'b0;
                        ep0_busy_next[ep0_pp_reg] = 1'b1;
                        off_next = off_reg + plen;
                        rem_next = rem_reg - plen;
                        ep0_tog_next = !ep0_tog_reg;
                        ep0_pp_next = !ep0_pp_reg;
                        pkt_cnt_next = pkt_cnt_reg + 2'd1;
                        out_valid_next = 1'b1;
                        emitted_next = 1'b1;
                        // last if nothing further can follow
                        out_next.last = (pkt_cnt_reg == 2'd1) ||
                            (rem_next == '0) || ep0_busy_reg[!ep0_pp_reg];
                        if (out_next.last)
                        begin
                            ev_ready = 1'b1;
                            state_next = ST_HEAD;
                        end
                    end
                    else
                    begin
                        // close the event: the held result already carries last, else emit a none
                        ev_ready = 1'b1;
                        state_next = ST_HEAD;
                        if (!emitted_reg)
                        begin
                            out_next = '0;
                            out_next.last = 1'b1;
                            out_valid_next = 1'b1;
                        end
                    end
                end
                else if (emitted_reg && out_valid_reg && pkt_cnt_reg == '0)
                begin
                    out_next = out_reg;
                end
            end
            default:
                state_next = ST_HEAD;
        endcase
    end

endmodule

### rtl/usb_control_endpoint_responder_top.sv
// channel | handshake               | payload
// in      | in_valid / in_ready     | in_word  (in_word_t)
// out     | out_valid / out_ready   | out_word (out_word_t)
// an event takes a head step in the back end; setup, ep0 done and ep0 out events
// add a step per ep0 packet and a closing step when no packet ends the event
// reset: asynchronous, active low, clears all endpoint state
// a two word queue lets the front take events while the back end is stalled
module usb_control_endpoint_responder_top
    import ucer_pkg::*;
#(
    parameter int MAX_PACKET   = 64,
    parameter int REPORT_BYTES = 1,
    parameter int STRING_COUNT = 3
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  in_word_t  in_word,
    output logic      out_valid,
    input  logic      out_ready,
    output out_word_t out_word
);

    logic   ev_valid, ev_ready;
    event_t ev;

    ucer_front #(.STRING_COUNT(STRING_COUNT)) u_front (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_word(in_word),
        .ev_valid(ev_valid), .ev_ready(ev_ready), .ev(ev)
    );

    ucer_back #(.MAX_PACKET(MAX_PACKET), .REPORT_BYTES(REPORT_BYTES)) u_back (
        .clk(clk), .rst_n(rst_n),
        .ev_valid(ev_valid), .ev_ready(ev_ready), .ev(ev),
        .out_valid(out_valid), .out_ready(out_ready), .out_word(out_word)
    );

endmodule

### test/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import ucer_pkg::*;

    localparam int MAX_PKT     = 64;
    localparam int RPT_BYTES   = 1;
    localparam int NUM_STRINGS = 3;
    localparam int IDLE_LIMIT  = 20000;

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_ready;
    in_word_t  in_word;
    logic      out_valid;
    logic      out_ready;
    out_word_t out_word;

    usb_control_endpoint_responder_top u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_word   (in_word),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_word  (out_word)
    );

    // predicted endpoint state
    logic       m_ep0_pp;
    logic       m_ep0_tog;
    logic [1:0] m_ep0_busy;
    logic [7:0] m_remain;
    logic [2:0] m_desc;
    logic [7:0] m_offset;
    logic [6:0] m_pend_addr;
    logic       m_ep1_pp;
    logic       m_ep1_tog;
    logic [1:0] m_ep1_busy;

    in_word_t  pending_words[$];
    out_word_t expected_words[$];
    int        errors;
    int        idle_cycles;
    bit        hold_off_req;
    int        hold_off_left;

    initial clk = 1'b0;
    always #5 clk = ~clk;

    function automatic logic [7:0] desc_bytes(input logic [2:0] sel);
        case (sel)
            3'd0:    return 8'd18;
            3'd1:    return 8'd34;
            3'd2:    return 8'd23;
            3'd3:    return 8'd4;
            3'd4:    return 8'd18;
            3'd5:    return 8'd18;
            default: return 8'd0;
        endcase
    endfunction

    function automatic out_word_t make_word(input logic [2:0] act, input logic s,
                                            input logic tg, input logic [2:0] sel,
                                            input logic [7:0] off,
                                            input logic [6:0] len,
                                            input logic [6:0] addr);
        out_word_t w;
        w.action         = act;
        w.slot           = s;
        w.data_toggle    = tg;
        w.desc_select    = sel;
        w.byte_offset    = off;
        w.tx_len         = len;
        w.device_address = addr;
        w.last           = 1'b0;
        return w;
    endfunction

    task automatic clear_endpoints();
        m_ep0_pp    = 1'b0;
        m_ep0_tog   = 1'b0;
        m_ep0_busy  = 2'b00;
        m_remain    = 8'd0;
        m_desc      = 3'd0;
        m_offset    = 8'd0;
        m_pend_addr = 7'd0;
        m_ep1_pp    = 1'b0;
        m_ep1_tog   = 1'b0;
        m_ep1_busy  = 2'b00;
    endtask

    // predict the words one event produces and queue them
    task automatic predict_event(input in_word_t w);
        out_word_t res[$];
        out_word_t r;
        bit        zlp;
        bit        run0;
        bit        stall;
        bit        is_zlp;
        logic [2:0] sel;
        logic [7:0] len;
        logic [7:0] dtype;
        logic [7:0] idx;
        logic       s;
        zlp   = 0;
        run0  = 0;
        stall = 0;
        sel   = 3'd0;
        case (w.cmd)
            CMD_BUS_RESET: clear_endpoints();
            CMD_SETUP:
            begin
                m_ep0_busy = 2'b00;
                m_ep0_tog  = 1'b1;
                m_remain   = 8'd0;
                dtype      = w.setup_value[15:8];
                idx        = w.setup_value[7:0];
                if (w.request == REQ_SET_ADDRESS)
                begin
                    m_pend_addr = w.setup_value[6:0];
                    zlp = 1;
                end
                else if (w.request == REQ_SET_CONFIG)
                    zlp = 1;
                else if (w.request == REQ_GET_DESC)
                begin
                    if (dtype == DTYPE_STRING)
                    begin
                        if (idx >= NUM_STRINGS || idx >= 3)
                            stall = 1;
                        else
                            sel = SEL_STRING0 + idx[2:0];
                    end
                    else if (dtype == DTYPE_DEVICE)
                        sel = 3'd0;
                    else if (dtype == DTYPE_CONFIG)
                        sel = 3'd1;
                    else
                        stall = 1;
                end
                else if (w.request == REQ_GET_REPORT)
                    sel = 3'd2;
                else
                    stall = 1;
                if (stall)
                    res.push_back(make_word(ACT_STALL, 0, 0, 0, 0, 0, 0));
                else if (!zlp)
                begin
                    len = desc_bytes(sel);
                    if (len > w.setup_length)
                        len = w.setup_length[7:0];
                    m_remain = len;
                    m_desc   = sel;
                    m_offset = 8'd0;
                end
                run0 = 1;
            end
            CMD_EP0_DONE:
            begin
                m_ep0_busy[w.done_slot] = 1'b0;
                if (m_pend_addr != 0)
                begin
                    res.push_back(make_word(ACT_SET_ADDR, 0, 0, 0, 0, 0, m_pend_addr));
                    m_pend_addr = 7'd0;
                end
                run0 = 1;
            end
            CMD_EP0_OUT: run0 = 1;
            CMD_SOF:
                if (w.report_ready && !m_ep1_busy[m_ep1_pp])
                begin
                    res.push_back(make_word(ACT_EP1_QUEUE, m_ep1_pp, m_ep1_tog, 0, 0,
                                            7'(RPT_BYTES), 0));
                    m_ep1_busy[m_ep1_pp] = 1'b1;
                    m_ep1_tog = ~m_ep1_tog;
                    m_ep1_pp  = ~m_ep1_pp;
                end
            CMD_EP1_DONE: m_ep1_busy[w.done_slot] = 1'b0;
            default: ;
        endcase
        // ep0 packet queueing, at most two packets
        if (run0)
        begin
            for (int i = 0; i < 2 && (m_remain != 0 || zlp); i++)
            begin
                s      = m_ep0_pp;
                is_zlp = zlp && m_remain == 0;
                zlp    = 0;
                if (m_ep0_busy[s])
                    break;
                len = (m_remain > MAX_PKT) ? MAX_PKT[7:0] : m_remain;
                if (is_zlp)
                    res.push_back(make_word(ACT_EP0_QUEUE, s, m_ep0_tog, SEL_ZLP, 0, 0, 0));
                else
                    res.push_back(make_word(ACT_EP0_QUEUE, s, m_ep0_tog, m_desc, m_offset,
                                            len[6:0], 0));
                m_ep0_busy[s] = 1'b1;
                m_offset  = m_offset + len;
                m_remain  = m_remain - len;
                m_ep0_tog = ~m_ep0_tog;
                m_ep0_pp  = ~m_ep0_pp;
            end
        end
        if (res.size() == 0)
            res.push_back(make_word(ACT_NONE, 0, 0, 0, 0, 0, 0));
        r = res[res.size() - 1];
        r.last = 1'b1;
        res[res.size() - 1] = r;
        foreach (res[k])
            expected_words.push_back(res[k]);
    endtask

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch %s: got %0d expected %0d", what, got, want);
        errors++;
    endtask

    function automatic int gap_len();
        if ($urandom_range(0, 19) == 0)
            return $urandom_range(10, 40);
        else if ($urandom_range(0, 1) == 0)
            return 0;
        return $urandom_range(1, 3);
    endfunction

    // driver: presents queued words, random gaps between them
    int drv_gap;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_word  <= '0;
            drv_gap  <= 0;
        end
        else if (in_valid && !in_ready)
            ;
        else if (drv_gap > 0)
        begin
            in_valid <= 1'b0;
            drv_gap  <= drv_gap - 1;
        end
        else if (pending_words.size() > 0)
        begin
            in_valid <= 1'b1;
            in_word  <= pending_words[0];
            predict_event(pending_words.pop_front());
            drv_gap  <= gap_len();
        end
        else
            in_valid <= 1'b0;
    end

    // monitor: compares words and applies receiver stalls
    int mon_gap;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready     <= 1'b0;
            mon_gap       <= 0;
            hold_off_left <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_words.size() == 0)
                    report_mismatch("unexpected word", out_word.action, -1);
                else
                begin
                    out_word_t e;
                    e = expected_words.pop_front();
                    if (out_word.action != e.action)
                        report_mismatch("action", out_word.action, e.action);
                    if (out_word.slot != e.slot)
                        report_mismatch("slot", out_word.slot, e.slot);
                    if (out_word.data_toggle != e.data_toggle)
                        report_mismatch("data_toggle", out_word.data_toggle, e.data_toggle);
                    if (out_word.desc_select != e.desc_select)
                        report_mismatch("desc_select", out_word.desc_select, e.desc_select);
                    if (out_word.byte_offset != e.byte_offset)
                        report_mismatch("byte_offset", out_word.byte_offset, e.byte_offset);
                    if (out_word.tx_len != e.tx_len)
                        report_mismatch("tx_len", out_word.tx_len, e.tx_len);
                    if (out_word.device_address != e.device_address)
                        report_mismatch("device_address", out_word.device_address,
                                        e.device_address);
                    if (out_word.last != e.last)
                        report_mismatch("last", out_word.last, e.last);
                end
            end
            if (hold_off_req && hold_off_left == 0)
            begin
                hold_off_left <= 200;
                out_ready     <= 1'b0;
            end
            else if (hold_off_left > 1)
                hold_off_left <= hold_off_left - 1;
            else if (hold_off_left == 1)
            begin
                hold_off_left <= 0;
                out_ready     <= 1'b1;
            end
            else if (mon_gap > 0)
            begin
                mon_gap   <= mon_gap - 1;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= 1'b1;
                if ($urandom_range(0, 3) == 0)
                    mon_gap <= gap_len();
            end
        end
    end

    // watchdog on accepted traffic
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("testbench: FAIL");
            $finish;
        end
    end

    function automatic in_word_t ev(input cmd_t c, input logic [15:0] rq,
                                    input logic [15:0] v, input logic [15:0] ln,
                                    input logic d, input logic rr);
        in_word_t w;
        w.cmd          = c;
        w.request      = rq;
        w.setup_value  = v;
        w.setup_length = ln;
        w.done_slot    = d;
        w.report_ready = rr;
        return w;
    endfunction

    // event of the given command with random other fields
    function automatic in_word_t rand_fields(input cmd_t c);
        return ev(c, 16'($urandom), 16'($urandom), 16'($urandom),
                  1'($urandom), 1'($urandom));
    endfunction

    function automatic in_word_t rand_setup();
        logic [15:0] rq;
        logic [15:0] v;
        logic [15:0] ln;
        case ($urandom_range(0, 7))
            0: rq = REQ_SET_ADDRESS;
            1: rq = REQ_SET_CONFIG;
            2, 3, 4: rq = REQ_GET_DESC;
            5: rq = REQ_GET_REPORT;
            default: rq = 16'($urandom);
        endcase
        case ($urandom_range(0, 4))
            0: v = {DTYPE_DEVICE, 8'($urandom)};
            1: v = {DTYPE_CONFIG, 8'($urandom)};
            2, 3: v = {DTYPE_STRING, 8'($urandom_range(0, 4))};
            default: v = 16'($urandom);
        endcase
        ln = ($urandom_range(0, 2) == 0) ? 16'($urandom) : 16'($urandom_range(0, 40));
        return ev(CMD_SETUP, rq, v, ln, 1'($urandom), 1'($urandom));
    endfunction

    function automatic in_word_t rand_event();
        in_word_t w;
        case ($urandom_range(0, 11))
            0: w = rand_fields(CMD_BUS_RESET);
            1, 2, 3: w = rand_setup();
            4, 5, 6: w = rand_fields(CMD_EP0_DONE);
            7: w = rand_fields(CMD_EP0_OUT);
            8, 9: w = rand_fields(CMD_SOF);
            10: w = rand_fields(CMD_EP1_DONE);
            default:
            begin
                w = rand_fields(CMD_EP0_OUT);
                w.cmd = 3'($urandom_range(6, 7));
            end
        endcase
        return w;
    endfunction

    // stimulus
    initial
    begin
        int waited;
        errors       = 0;
        hold_off_req = 0;
        idle_cycles  = 0;
        clear_endpoints();
        rst_n = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // directed: requests, extremes, stalls, slot exhaustion
        pending_words.push_back(ev(CMD_SETUP, REQ_SET_ADDRESS, 16'hFFFF, 16'h0, 0, 0));
        pending_words.push_back(ev(CMD_EP0_DONE, 0, 0, 0, 0, 0));
        pending_words.push_back(ev(CMD_SETUP, REQ_SET_ADDRESS, 16'h0000, 16'hFFFF, 1, 1));
        pending_words.push_back(ev(CMD_EP0_DONE, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1, 1));
        pending_words.push_back(ev(CMD_SETUP, REQ_SET_CONFIG, 16'h0001, 0, 0, 0));
        pending_words.push_back(ev(CMD_SETUP, REQ_GET_DESC, 16'h0100, 16'hFFFF, 0, 0));
        pending_words.push_back(ev(CMD_SETUP, REQ_GET_DESC, 16'h0200, 16'hFFFF, 0, 0));
        pending_words.push_back(ev(CMD_SETUP, REQ_GET_DESC, 16'h0200, 16'd8, 0, 0));
        pending_words.push_back(ev(CMD_EP0_OUT, 0, 0, 0, 0, 0));
        pending_words.push_back(ev(CMD_SETUP, REQ_GET_REPORT, 16'h2200, 16'd0, 0, 0));
        pending_words.push_back(ev(CMD_SETUP, REQ_GET_REPORT, 16'h2200, 16'd5, 0, 0));
        for (int i = 0; i < 4; i++)
            pending_words.push_back(ev(CMD_SETUP, REQ_GET_DESC, {DTYPE_STRING, 8'(i)},
                                       16'd64, 0, 0));
        pending_words.push_back(ev(CMD_SETUP, REQ_GET_DESC, 16'h03FF, 16'd64, 0, 0));
        pending_words.push_back(ev(CMD_SETUP, REQ_GET_DESC, 16'h0400, 16'd64, 0, 0));
        pending_words.push_back(ev(CMD_SETUP, 16'hFFFF, 16'h0100, 16'd64, 0, 0));
        pending_words.push_back(ev(CMD_SOF, 0, 0, 0, 0, 1));
        pending_words.push_back(ev(CMD_SOF, 0, 0, 0, 0, 1));
        pending_words.push_back(ev(CMD_SOF, 0, 0, 0, 0, 1));
        pending_words.push_back(ev(CMD_SOF, 0, 0, 0, 0, 0));
        pending_words.push_back(ev(CMD_EP1_DONE, 0, 0, 0, 1, 0));
        pending_words.push_back(ev(CMD_EP1_DONE, 0, 0, 0, 0, 0));
        pending_words.push_back(ev(CMD_BUS_RESET, 0, 0, 0, 0, 0));
        pending_words.push_back(ev(CMD_EP0_OUT, 0, 0, 0, 0, 0));
        pending_words.push_back(ev(cmd_t'(3'd7), 0, 0, 0, 0, 0));

        // receiver holds off while the sender keeps offering
        hold_off_req = 1;
        for (int i = 0; i < 12; i++)
            pending_words.push_back(rand_event());
        wait (hold_off_left != 0);
        hold_off_req = 0;
        while (pending_words.size() > 0)
            @(posedge clk);

        // sender pauses until everything has drained
        waited = 0;
        while (expected_words.size() > 0 && waited < IDLE_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end

        // random part: mostly well-formed transfers
        for (int i = 0; i < 100; i++)
        begin
            if ($urandom_range(0, 2) == 0)
            begin
                pending_words.push_back(rand_setup());
                pending_words.push_back(rand_fields(CMD_EP0_DONE));
            end
            else
                pending_words.push_back(rand_event());
        end
        while (pending_words.size() > 0 || (in_valid && !in_ready))
            @(posedge clk);

        waited = 0;
        while (expected_words.size() > 0 && waited < IDLE_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (50) @(posedge clk);
        if (errors == 0 && expected_words.size() == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end

endmodule

### sim.f
rtl/ucer_pkg.sv
rtl/ucer_front.sv
rtl/ucer_back.sv
rtl/usb_control_endpoint_responder_top.sv
test/testbench.sv
